### hdl/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants for the trilinear reflectance lookup
// Field widths, grid limits and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package lts_pkg;
  localparam int unsigned MaxBands  = 8;
  localparam int unsigned MaxAngles = 16;
  localparam int unsigned MaxDust   = 16;
  localparam int unsigned MaxGrain  = 32;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned WordW     = 16;
  localparam int unsigned PosW      = 13;
  localparam int unsigned CfgW      = 6;

  typedef enum logic [1:0] {
    RegBandCount  = 2'd0,
    RegAngleCount = 2'd1,
    RegDustCount  = 2'd2,
    RegGrainCount = 2'd3
  } cfg_reg_e;

  // Clamp a count register into [1, hi].
  function automatic logic [6:0] clamp_count(input logic [5:0] v, input logic [6:0] hi);
    logic [6:0] r;
    begin
      r = {1'b0, v};
      if (v == 6'd0) r = 7'd1;
      else if ({1'b0, v} > hi) r = hi;
      return r;
    end
  endfunction
endpackage
`default_nettype wire

### hdl/lut_trilinear_spectrum_interp_unit.sv
// ----------------------------------------------------------------------------
// lut_trilinear_spectrum_interp_unit: trilinear reflectance table lookup
// Holds a 64K-word table; a query gives one interpolated value per band.
// ----------------------------------------------------------------------------
// A write transaction (kind 0) stores one word in the table. A query
// (kind 1) reads the eight corner words of each band one after another from
// a synchronous table memory; busy is high from acceptance until the last
// band is emitted, and no new write or query is taken meanwhile. The setup
// states StPrep and StGeom precompute the grid offsets, then each band
// passes through StAddr (issuing the corner addresses), StRead (the multiply
// pipeline drains) and StEmit. Each result shows for one cycle with valid_o;
// the receiver cannot stall it.
`default_nettype none
module lut_trilinear_spectrum_interp_unit import lts_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_index_i,
  input  wire logic [CfgW-1:0]        cfg_data_i,
  input  wire logic                   kind_i,
  input  wire logic [AddrW-1:0]       table_address_i,
  input  wire logic signed [WordW-1:0] table_value_i,
  input  wire logic [PosW-1:0]        angle_position_i,
  input  wire logic [PosW-1:0]        dust_position_i,
  input  wire logic [PosW-1:0]        grain_position_i,
  output logic                        valid_o,
  output logic [2:0]                  band_number_o,
  output logic signed [WordW-1:0]     reflectance_o,
  output logic                        out_of_range_o,
  output logic                        last_band_o
);
  typedef enum logic [2:0] {StIdle, StPrep, StGeom, StAddr, StRead, StEmit} state_e;

  state_e      state_q;
  logic [3:0]  band_cnt_q;
  logic [4:0]  angle_cnt_q, dust_cnt_q;
  logic [5:0]  grain_cnt_q;
  logic [3:0]  nb_q;
  logic [6:0]  na_q, nd_q, ng_q;
  logic [PosW-1:0] pa_q, pd_q, pg_q;
  logic [5:0]  ia0_q, ia1_q, id0_q, id1_q, ig0_q, ig1_q;
  logic        err_q;
  logic [2:0]  band_q;
  logic [3:0]  corner_q;     // corner being addressed, bit 3 = done
  logic [AddrW-1:0] plane_q;      // nd * ng
  logic [AddrW-1:0] cube_q;       // na * nd * ng, stride between bands
  logic [AddrW-1:0] band_base_q;
  logic [AddrW-1:0] aoff0_q, aoff1_q, doff0_q, doff1_q;
  logic [WordW-1:0] mem [2**AddrW];
  logic [WordW-1:0] rdata_q;
  logic        rd_valid_q, rd_valid_d1_q;
  logic [16:0] wad_q;        // wa*wd, up to 65536
  logic [8:0]  wg_q;
  logic signed [WordW-1:0] word_q;
  logic [24:0] wt_q;         // wa*wd*wg, up to 2^24
  logic signed [43:0] acc_q;
  logic [AddrW-1:0] addr;
  logic [AddrW-1:0] a_off, d_off;
  logic [5:0]  ig_sel;
  logic [8:0]  wa, wd, wg;
  logic signed [41:0] prod;
  logic [44:0] biased;
  logic        acc_clr;

  // corner select bits: bit2 angle, bit1 dust, bit0 grain
  always_comb begin
    a_off  = corner_q[2] ? aoff1_q : aoff0_q;
    d_off  = corner_q[1] ? doff1_q : doff0_q;
    ig_sel = corner_q[0] ? ig1_q : ig0_q;
    addr   = band_base_q + a_off + d_off + AddrW'(ig_sel);
  end

  always_comb begin
    wa = corner_q[2] ? {1'b0, pa_q[7:0]} : 9'd256 - {1'b0, pa_q[7:0]};
    wd = corner_q[1] ? {1'b0, pd_q[7:0]} : 9'd256 - {1'b0, pd_q[7:0]};
    wg = corner_q[0] ? {1'b0, pg_q[7:0]} : 9'd256 - {1'b0, pg_q[7:0]};
    prod   = 42'(word_q) * 42'(signed'({1'b0, wt_q}));
    biased = 45'(acc_q) + (45'd1 << 39) + (45'd1 << 23);
    acc_clr = (state_q == StGeom) || (state_q == StEmit);
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy && !kind_i) mem[table_address_i] <= table_value_i;
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_cnt_q <= 4'd7; angle_cnt_q <= 5'd16; dust_cnt_q <= 5'd16; grain_cnt_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegBandCount:  band_cnt_q  <= cfg_data_i[3:0];
        RegAngleCount: angle_cnt_q <= cfg_data_i[4:0];
        RegDustCount:  dust_cnt_q  <= cfg_data_i[4:0];
        RegGrainCount: grain_cnt_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; valid_o <= 1'b0; rd_valid_q <= 1'b0; rd_valid_d1_q <= 1'b0;
      band_q <= '0; corner_q <= '0; nb_q <= '0; na_q <= '0; nd_q <= '0; ng_q <= '0;
      pa_q <= '0; pd_q <= '0; pg_q <= '0; err_q <= 1'b0;
      ia0_q <= '0; ia1_q <= '0; id0_q <= '0; id1_q <= '0; ig0_q <= '0; ig1_q <= '0;
      plane_q <= '0; cube_q <= '0; band_base_q <= '0;
      aoff0_q <= '0; aoff1_q <= '0; doff0_q <= '0; doff1_q <= '0;
      wad_q <= '0; wg_q <= '0; word_q <= '0; wt_q <= '0; acc_q <= '0;
      band_number_o <= '0; reflectance_o <= '0; out_of_range_o <= 1'b0;
      last_band_o <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      case (state_q)
        StIdle: if (start && kind_i) begin
          nb_q <= 4'(clamp_count({2'b0, band_cnt_q}, 7'(MaxBands)));
          na_q <= clamp_count({1'b0, angle_cnt_q}, 7'(MaxAngles));
          nd_q <= clamp_count({1'b0, dust_cnt_q}, 7'(MaxDust));
          ng_q <= clamp_count(grain_cnt_q, 7'(MaxGrain));
          pa_q <= angle_position_i; pd_q <= dust_position_i; pg_q <= grain_position_i;
          band_q <= '0;
          state_q <= StPrep;
        end
        StPrep: begin
          err_q <= ({2'b0, pa_q} > 15'({na_q - 7'd1, 8'd0})) ||
                   ({2'b0, pd_q} > 15'({nd_q - 7'd1, 8'd0})) ||
                   ({2'b0, pg_q} > 15'({ng_q - 7'd1, 8'd0}));
          ia0_q <= {1'b0, pa_q[12:8]};
          id0_q <= {1'b0, pd_q[12:8]};
          ig0_q <= {1'b0, pg_q[12:8]};
          ia1_q <= (7'(pa_q[12:8]) + 7'd1 > na_q - 7'd1) ? 6'(na_q - 7'd1) : 6'(pa_q[12:8]) + 6'd1;
          id1_q <= (7'(pd_q[12:8]) + 7'd1 > nd_q - 7'd1) ? 6'(nd_q - 7'd1) : 6'(pd_q[12:8]) + 6'd1;
          ig1_q <= (7'(pg_q[12:8]) + 7'd1 > ng_q - 7'd1) ? 6'(ng_q - 7'd1) : 6'(pg_q[12:8]) + 6'd1;
          plane_q <= AddrW'(nd_q) * AddrW'(ng_q);
          state_q <= StGeom;
        end
        StGeom: begin
          cube_q  <= AddrW'(na_q) * plane_q;
          aoff0_q <= AddrW'(ia0_q) * plane_q;
          aoff1_q <= AddrW'(ia1_q) * plane_q;
          doff0_q <= AddrW'(id0_q) * AddrW'(ng_q);
          doff1_q <= AddrW'(id1_q) * AddrW'(ng_q);
          band_base_q <= '0;
          corner_q <= '0;
          state_q <= StAddr;
        end
        StAddr: begin
          // issue one corner read per cycle; accumulate as words return
          if (!corner_q[3]) corner_q <= corner_q + 4'd1;
          else state_q <= StRead;
        end
        StRead: state_q <= StEmit;
        StEmit: begin
          valid_o <= 1'b1;
          band_number_o <= band_q;
          out_of_range_o <= err_q;
          reflectance_o <= err_q ? '0 : WordW'(biased[44:24] - 21'd32768);
          last_band_o <= (4'(band_q) + 4'd1 == nb_q);
          if (4'(band_q) + 4'd1 == nb_q) state_q <= StIdle;
          else begin
            band_q <= band_q + 3'd1; corner_q <= '0;
            band_base_q <= band_base_q + cube_q;
            state_q <= StAddr;
          end
        end
        default: state_q <= StIdle;
      endcase
      // read data, weights and product advance one stage per cycle
      rd_valid_q    <= (state_q == StAddr) && !corner_q[3];
      rd_valid_d1_q <= rd_valid_q;
      wad_q  <= 17'(wa) * 17'(wd);
      wg_q   <= wg;
      word_q <= rdata_q;
      wt_q   <= 25'(wad_q) * 25'(wg_q);
      if (acc_clr) acc_q <= '0;
      else if (rd_valid_d1_q) acc_q <= acc_q + 44'(prod);
    end
  end

  assign busy = (state_q != StIdle);

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_band_o |-> state_q == StIdle) else $error("last band not at end");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && out_of_range_o |-> reflectance_o == '0) else $error("error nonzero");
  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> 4'(band_number_o) < nb_q) else $error("band beyond count");
endmodule
`default_nettype wire
